// ===== rtl/tun_pkg.sv =====
// Shared types and constants for the triangle unit normal pipeline.
// No dependencies.
package tun_pkg;

   // Result component width and saturation bounds (signed)
   localparam int OUT_BITS = 16;
   localparam logic [OUT_BITS-1:0] OUT_LIM = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   // Vector components and vertex coordinates per word
   localparam int AXES   = 3;
   localparam int COORDS = 9;

   // Sideband that travels with every word through the pipeline
   typedef struct packed {
      logic             deg;
      logic [AXES-1:0]  neg;
   } tun_side_type;

endpackage

// ===== rtl/tun_front.sv =====
// Front end: edge vectors, cross product, squared components and their sum.
// Five register stages. Depends on tun_pkg.
module tun_front #(
   parameter int CB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [CB-1:0]        in_p [tun_pkg::COORDS],
   output logic                 out_valid,
   output tun_pkg::tun_side_type out_side,
   output logic [4*CB+7:0]      out_sum,
   output logic [4*CB+7:0]      out_sq [tun_pkg::AXES]
);
   import tun_pkg::*;

   localparam int E  = CB + 1;      // edge width
   localparam int PW = 2 * E;       // product width
   localparam int MW = 2 * E + 1;   // cross magnitude width
   localparam int SW = 2 * MW + 2;  // sum of squares width

   logic [4:0] valid_ff;

   logic signed [E-1:0]  u_ff [AXES];
   logic signed [E-1:0]  v_ff [AXES];
   logic signed [PW-1:0] prod_ff [6];
   logic [MW-1:0]        mag_ff [AXES];
   logic [AXES-1:0]      neg3_ff, neg4_ff, neg5_ff;
   logic [2*MW-1:0]      sq_ff [AXES];
   logic [SW-1:0]        sum_ff;
   logic [SW-1:0]        sqx_ff [AXES];

   logic signed [E-1:0]  pe [COORDS];
   logic signed [MW-1:0] cr [AXES];

   // sign-extend the coordinates by one bit
   always_comb begin
      for (int i = 0; i < COORDS; i++) begin
         pe[i] = {in_p[i][CB-1], in_p[i]};
      end
   end

   // cross product differences
   always_comb begin
      cr[0] = {prod_ff[0][PW-1], prod_ff[0]} - {prod_ff[1][PW-1], prod_ff[1]};
      cr[1] = {prod_ff[2][PW-1], prod_ff[2]} - {prod_ff[3][PW-1], prod_ff[3]};
      cr[2] = {prod_ff[4][PW-1], prod_ff[4]} - {prod_ff[5][PW-1], prod_ff[5]};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            u_ff[i] <= pe[3 + i] - pe[i];
            v_ff[i] <= pe[6 + i] - pe[3 + i];
         end
         prod_ff[0] <= u_ff[1] * v_ff[2];
         prod_ff[1] <= u_ff[2] * v_ff[1];
         prod_ff[2] <= u_ff[2] * v_ff[0];
         prod_ff[3] <= u_ff[0] * v_ff[2];
         prod_ff[4] <= u_ff[0] * v_ff[1];
         prod_ff[5] <= u_ff[1] * v_ff[0];
         for (int i = 0; i < AXES; i++) begin
            neg3_ff[i] <= cr[i][MW-1];
            mag_ff[i]  <= cr[i][MW-1] ? MW'(-cr[i]) : MW'(cr[i]);
            sq_ff[i]   <= mag_ff[i] * mag_ff[i];
            sqx_ff[i]  <= SW'(sq_ff[i]);
         end
         neg4_ff <= neg3_ff;
         neg5_ff <= neg4_ff;
         sum_ff  <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      end
   end

   assign out_valid    = valid_ff[4];
   assign out_side.neg = neg5_ff;
   assign out_side.deg = (sum_ff == '0);
   assign out_sum      = sum_ff;
   assign out_sq       = sqx_ff;

endmodule

// ===== rtl/tun_divider.sv =====
// Pipelined restoring divider: quotient of a^2 * 2^(QB-1) / S, one bit per stage.
// Three lanes share the divisor. Depends on tun_pkg.
module tun_divider #(
   parameter int SW = 72,
   parameter int QB = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tun_pkg::tun_side_type in_side,
   input  logic [SW-1:0]        in_sum,
   input  logic [SW-1:0]        in_sq [tun_pkg::AXES],
   output logic                 out_valid,
   output tun_pkg::tun_side_type out_side,
   output logic [QB-1:0]        out_quo [tun_pkg::AXES]
);
   import tun_pkg::*;

   logic               valid_ff [QB];
   tun_side_type       side_ff  [QB];
   logic [SW-1:0]      sum_ff   [QB];
   logic [SW:0]        rem_ff   [QB][AXES];
   logic [QB-1:0]      quo_ff   [QB][AXES];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic          valid_prev;
      tun_side_type  side_prev;
      logic [SW-1:0] sum_prev;
      logic [SW:0]   rem_prev [AXES];
      logic [QB-1:0] quo_prev [AXES];

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
         assign sum_prev   = in_sum;
         for (genvar l = 0; l < AXES; l++) begin : g_ln
            assign rem_prev[l] = {1'b0, in_sq[l]};
            assign quo_prev[l] = '0;
         end
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign sum_prev   = sum_ff[k-1];
         for (genvar l = 0; l < AXES; l++) begin : g_ln
            assign rem_prev[l] = rem_ff[k-1][l];
            assign quo_prev[l] = quo_ff[k-1][l];
         end
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_prev;
            sum_ff[k]  <= sum_prev;
         end
      end

      // one quotient bit per lane: shift, compare, subtract
      for (genvar l = 0; l < AXES; l++) begin : g_lane
         logic [SW:0] shifted;
         logic        ge;
         assign shifted = (k == 0) ? rem_prev[l] : {rem_prev[l][SW-1:0], 1'b0};
         assign ge      = (shifted >= {1'b0, sum_prev});
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= ge ? (shifted - {1'b0, sum_prev}) : shifted;
               quo_ff[k][l] <= {quo_prev[l][QB-2:0], ge};
            end
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_side  = side_ff[QB-1];
   assign out_quo   = quo_ff[QB-1];

endmodule

// ===== rtl/tun_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage, three lanes.
// Depends on tun_pkg.
module tun_sqrt #(
   parameter int RB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tun_pkg::tun_side_type in_side,
   input  logic [2*RB-2:0]      in_rad [tun_pkg::AXES],
   output logic                 out_valid,
   output tun_pkg::tun_side_type out_side,
   output logic [RB-1:0]        out_root [tun_pkg::AXES]
);
   import tun_pkg::*;

   logic               valid_ff [RB];
   tun_side_type       side_ff  [RB];
   logic [2*RB-1:0]    rad_ff   [RB][AXES];
   logic [RB:0]        rem_ff   [RB][AXES];
   logic [RB-1:0]      root_ff  [RB][AXES];

   for (genvar k = 0; k < RB; k++) begin : g_stage
      logic            valid_prev;
      tun_side_type    side_prev;
      logic [2*RB-1:0] rad_prev  [AXES];
      logic [RB:0]     rem_prev  [AXES];
      logic [RB-1:0]   root_prev [AXES];

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
         for (genvar l = 0; l < AXES; l++) begin : g_ln
            assign rad_prev[l]  = {1'b0, in_rad[l]};
            assign rem_prev[l]  = '0;
            assign root_prev[l] = '0;
         end
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
         for (genvar l = 0; l < AXES; l++) begin : g_ln
            assign rad_prev[l]  = rad_ff[k-1][l];
            assign rem_prev[l]  = rem_ff[k-1][l];
            assign root_prev[l] = root_ff[k-1][l];
         end
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_prev;
         end
      end

      // bring down two radicand bits, try root*4+1
      for (genvar l = 0; l < AXES; l++) begin : g_lane
         logic [RB+1:0] rem_sh;
         logic [RB+1:0] trial;
         logic          ge;
         assign rem_sh = {rem_prev[l][RB-1:0], rad_prev[l][2*RB-1:2*RB-2]};
         assign trial  = {root_prev[l], 2'b01};
         assign ge     = (rem_sh >= trial);
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l]  <= ge ? (RB+1)'(rem_sh - trial) : (RB+1)'(rem_sh);
               root_ff[k][l] <= {root_prev[l][RB-2:0], ge};
               rad_ff[k][l]  <= {rad_prev[l][2*RB-3:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = valid_ff[RB-1];
   assign out_side  = side_ff[RB-1];
   assign out_root  = root_ff[RB-1];

endmodule

// ===== rtl/triangle_unit_normal_core.sv =====
// Triangle unit normal: top level of the pipeline.
// Depends on tun_pkg, tun_front, tun_divider, tun_sqrt.
//
// Usage:
//   Input channel req_*: one word carries three vertices (nine signed
//   COORD_BITS coordinates). A word is taken on a clock edge with
//   req_valid high and req_stall low.
//   Result channel rsp_*: one word per input word, in order: the unit
//   normal (signed, NORMAL_FRAC_BITS fraction bits, rounded to nearest)
//   and rsp_degenerate, set with a zero normal when the cross product
//   has zero length.
//   The pipe has five front stages, one divider stage per quotient
//   bit, one square root stage per root bit and one output register.
//   Throughput is one word per cycle while no shown result is stalled;
//   every stage holds one word.
//   When the receiver stalls while a result is shown, the whole pipe
//   freezes and req_stall rises in the same cycle; nothing is lost.
//   Reset clears all valid bits; the pipe is empty afterward.
module triangle_unit_normal_core #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_BITS-1:0]        req_p1_x,
   input  logic signed [COORD_BITS-1:0]        req_p1_y,
   input  logic signed [COORD_BITS-1:0]        req_p1_z,
   input  logic signed [COORD_BITS-1:0]        req_p2_x,
   input  logic signed [COORD_BITS-1:0]        req_p2_y,
   input  logic signed [COORD_BITS-1:0]        req_p2_z,
   input  logic signed [COORD_BITS-1:0]        req_p3_x,
   input  logic signed [COORD_BITS-1:0]        req_p3_y,
   input  logic signed [COORD_BITS-1:0]        req_p3_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tun_pkg::OUT_BITS-1:0] rsp_normal_x,
   output logic signed [tun_pkg::OUT_BITS-1:0] rsp_normal_y,
   output logic signed [tun_pkg::OUT_BITS-1:0] rsp_normal_z,
   output logic                                rsp_degenerate
);
   import tun_pkg::*;

   localparam int SW = 4 * COORD_BITS + 8;        // sum of squares width
   localparam int QB = 2 * NORMAL_FRAC_BITS + 3;  // quotient bits
   localparam int RB = NORMAL_FRAC_BITS + 2;      // root bits
   localparam int CW = (RB + 1 > OUT_BITS) ? RB + 1 : OUT_BITS;

   logic en;
   logic [COORDS-1:0] unused_mask;

   logic [COORD_BITS-1:0] coords [COORDS];

   logic          fr_valid;
   tun_side_type  fr_side;
   logic [SW-1:0] fr_sum;
   logic [SW-1:0] fr_sq [AXES];

   logic          dv_valid;
   tun_side_type  dv_side;
   logic [QB-1:0] dv_quo [AXES];

   logic          sq_valid;
   tun_side_type  sq_side;
   logic [RB-1:0] sq_root [AXES];

   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] normal_ff [AXES];
   logic                deg_ff;
   logic [OUT_BITS-1:0] normal_in [AXES];

   // global advance: freeze only while a shown result is stalled
   assign en          = !(rsp_valid_ff && rsp_stall);
   assign req_stall   = !en;
   assign unused_mask = '0;

   assign coords[0] = req_p1_x;
   assign coords[1] = req_p1_y;
   assign coords[2] = req_p1_z;
   assign coords[3] = req_p2_x;
   assign coords[4] = req_p2_y;
   assign coords[5] = req_p2_z;
   assign coords[6] = req_p3_x;
   assign coords[7] = req_p3_y;
   assign coords[8] = req_p3_z;

   tun_front #(.CB(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_p      (coords),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_sum   (fr_sum),
      .out_sq    (fr_sq)
   );

   tun_divider #(.SW(SW), .QB(QB)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_sum    (fr_sum),
      .in_sq     (fr_sq),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   tun_sqrt #(.RB(RB)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_rad    (dv_quo),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // round half up on the doubled root, saturate, apply sign; zero the normal of a degenerate word
   always_comb begin
      logic [RB:0]         rnd;
      logic [CW-1:0]       ext;
      logic [OUT_BITS-1:0] mag;
      for (int i = 0; i < AXES; i++) begin
         rnd = ({1'b0, sq_root[i]} + (RB+1)'(1)) >> 1;
         ext = CW'(rnd);
         mag = (ext > CW'(OUT_LIM)) ? OUT_LIM : ext[OUT_BITS-1:0];
         if (sq_side.deg) begin
            normal_in[i] = '0;
         end else if (sq_side.neg[i] | unused_mask[i]) begin
            normal_in[i] = -mag;
         end else begin
            normal_in[i] = mag;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         normal_ff <= normal_in;
         deg_ff    <= sq_side.deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = normal_ff[0];
   assign rsp_normal_y   = normal_ff[1];
   assign rsp_normal_z   = normal_ff[2];
   assign rsp_degenerate = deg_ff;

`ifndef SYNTHESIS
   // input is held off exactly when a shown result is stalled
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not track output stall");

   // a degenerate result carries a zero normal
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate result with nonzero normal");

   // saturation is symmetric: the most negative code never appears
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x != OUT_MIN && rsp_normal_y != OUT_MIN
                     && rsp_normal_z != OUT_MIN))
      else $error("normal component hit the most negative code");

   // a non-degenerate normal is never all zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0))
      else $error("non-degenerate result with zero normal");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for triangle_unit_normal_core: random and corner triangles in, unit
// normals checked against an exact fixed-point predictor. Depends on tun_pkg and the core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tun_pkg::*;

   localparam int CB = 16;
   localparam int FB = 14;
   localparam int LATENCY = 3*FB + 11;

   typedef struct {
      logic signed [CB-1:0] p [9];
   } tri_word_type;

   typedef struct {
      logic signed [OUT_BITS-1:0] nx, ny, nz;
      logic                       deg;
   } normal_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CB-1:0] req_p [9];
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   tri_word_type    tri_queue [$];
   normal_word_type normal_queue [$];
   int  errors = 0;
   int  n_checked = 0;
   int  n_degen = 0;
   int  cycles = 0;
   bit  stim_done = 0;

   always #5 clock = ~clock;

   initial foreach (req_p[i]) req_p[i] = '0;

   triangle_unit_normal_core #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(FB)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_p1_x(req_p[0]), .req_p1_y(req_p[1]), .req_p1_z(req_p[2]),
      .req_p2_x(req_p[3]), .req_p2_y(req_p[4]), .req_p2_z(req_p[5]),
      .req_p3_x(req_p[6]), .req_p3_y(req_p[7]), .req_p3_z(req_p[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   // Rounded magnitude of a*2^FB/sqrt(s): largest m with m^2*s <= a^2*2^(2FB+2), then halve and saturate
   function automatic logic [OUT_BITS-1:0] unit_mag(logic [63:0] a, logic [127:0] s);
      logic [191:0] rhs, lhs;
      logic [63:0]  lo, hi, mid;
      rhs = ({128'b0, a} * {128'b0, a}) << (2*FB + 2);
      lo = 0;
      hi = 64'd1 << (FB + 1);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         lhs = {128'b0, mid} * {128'b0, mid} * {64'b0, s};
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      lo = (lo + 1) >> 1;
      if (lo > OUT_LIM) lo = OUT_LIM;
      return lo[OUT_BITS-1:0];
   endfunction

   // Exact cross product of the edges, then normalize
   function automatic normal_word_type predict_normal(tri_word_type t);
      normal_word_type r;
      longint u [3], v [3], c [3];
      logic [63:0]  a [3];
      logic [127:0] s;
      logic [OUT_BITS-1:0] m;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'(t.p[3+i]) - longint'(t.p[i]);
         v[i] = longint'(t.p[6+i]) - longint'(t.p[3+i]);
      end
      c[0] = u[1]*v[2] - u[2]*v[1];
      c[1] = u[2]*v[0] - u[0]*v[2];
      c[2] = u[0]*v[1] - u[1]*v[0];
      s = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? -c[i] : c[i];
         s += {64'b0, a[i]} * {64'b0, a[i]};
      end
      r.deg = (s == 0);
      r.nx = 0; r.ny = 0; r.nz = 0;
      if (!r.deg) begin
         m = unit_mag(a[0], s); r.nx = c[0] < 0 ? -m : m;
         m = unit_mag(a[1], s); r.ny = c[1] < 0 ? -m : m;
         m = unit_mag(a[2], s); r.nz = c[2] < 0 ? -m : m;
      end
      return r;
   endfunction

   function automatic logic signed [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return CB'($signed($urandom_range(0, 64)) - 32);
         default: return CB'($urandom);
      endcase
   endfunction

   // Directed corners, then random triangles
   initial begin
      tri_word_type t;
      int base;
      // coincident vertices
      foreach (t.p[i]) t.p[i] = 0;
      tri_queue.push_back(t);
      foreach (t.p[i]) t.p[i] = 16'sh7fff;
      tri_queue.push_back(t);
      // collinear
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6};
      tri_queue.push_back(t);
      // axis-aligned normals, both signs
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0};
      tri_queue.push_back(t);
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd256, 16'sd0};
      tri_queue.push_back(t);
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1};
      tri_queue.push_back(t);
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd1};
      tri_queue.push_back(t);
      // diagonal normal, rounding-sensitive
      t.p = '{16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd1, 16'sd0, -16'sd1};
      tri_queue.push_back(t);
      // extreme edges: full-range coordinates
      t.p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh8000};
      tri_queue.push_back(t);
      t.p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh7fff};
      tri_queue.push_back(t);
      t.p = '{16'sh8000, 16'sh7fff, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh8000};
      tri_queue.push_back(t);
      // random, with some degenerate ones mixed in
      for (int n = 0; n < 400; n++) begin
         foreach (t.p[i]) t.p[i] = rand_coord();
         if ($urandom_range(0, 15) == 0) begin
            base = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) t.p[6+i] = t.p[3*base + i];
         end
         tri_queue.push_back(t);
      end
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 0;
   end

   // Stall sampled at the rising edge so the driver sees the handshake outcome
   logic req_stall_s = 0;
   always @(posedge clock) begin
      req_stall_s <= req_stall;
      if (!reset && req_valid && !req_stall)
         normal_queue.push_back(predict_normal(tri_queue[0]));
   end

   // Driver: present words at the falling edge with random gaps
   int gap = 0;
   bit accepted;
   always @(negedge clock) begin
      if (!reset) begin
         accepted = req_valid && !req_stall_s;
         if (accepted) void'(tri_queue.pop_front());
         if (req_valid && !accepted) begin
            // hold the word
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_valid <= 0;
         end else if (tri_queue.size() > 0) begin
            foreach (req_p[i]) req_p[i] <= tri_queue[0].p[i];
            req_valid <= 1;
            gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end else begin
            req_valid <= 0;
            stim_done <= 1;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off to back up the pipe
   int stall_left = 0;
   bit long_done = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1;
         end else if (!long_done && normal_queue.size() > 10) begin
            long_done <= 1;
            stall_left <= 200;
            rsp_stall <= 1;
         end else if (rsp_stall == 0 && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      normal_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normal_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word %0d %0d %0d deg=%0b", $realtime,
                     rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
         end else begin
            e = normal_queue.pop_front();
            n_checked++;
            if (e.deg) n_degen++;
            if (rsp_normal_x !== e.nx) begin
               errors++;
               $display("%0t: normal_x expected %0d got %0d", $realtime, e.nx, rsp_normal_x);
            end
            if (rsp_normal_y !== e.ny) begin
               errors++;
               $display("%0t: normal_y expected %0d got %0d", $realtime, e.ny, rsp_normal_y);
            end
            if (rsp_normal_z !== e.nz) begin
               errors++;
               $display("%0t: normal_z expected %0d got %0d", $realtime, e.nz, rsp_normal_z);
            end
            if (rsp_degenerate !== e.deg) begin
               errors++;
               $display("%0t: degenerate expected %0b got %0b", $realtime, e.deg,
                        rsp_degenerate);
            end
         end
      end
   end

   // End of run and watchdog
   initial begin
      wait (stim_done && normal_queue.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d normals, %0d of them degenerate, under random gaps and stalls.",
               n_checked, n_degen);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end
endmodule

// ===== triangle_unit_normal_core.f =====
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_divider.sv
rtl/tun_sqrt.sv
rtl/triangle_unit_normal_core.sv
tb/tb.sv
